[rtl/plob_pkg.sv]
// shared types, codes and constants for the price-level order book
// no dependencies
package plob_pkg;

  localparam int LEVELS_DEF = 16;
  localparam int PRICE_W = 31;
  localparam int VOL_W = 31;
  localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] STAT_NEW = 3'd0;
  localparam logic [2:0] STAT_MERGED = 3'd1;
  localparam logic [2:0] STAT_DROPPED = 3'd2;
  localparam logic [2:0] STAT_PARTIAL = 3'd3;
  localparam logic [2:0] STAT_REMOVED = 3'd4;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd5;
  localparam logic [2:0] STAT_CLEARED = 3'd6;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MERGE,
    OP_INSERT,
    OP_REDUCE,
    OP_REMOVE,
    OP_COMPACT
  } op_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
    logic               mark;
  } level_t;

  typedef struct packed {
    op_t                op;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
    logic               mark;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic at_p;
    logic past_p;
  } pos_t;

  typedef struct packed {
    logic             match;
    logic             better;
    logic             drains;
    logic             drop;
    logic [VOL_W-1:0] take;
  } cell_flag_t;

  typedef struct packed {
    logic             any_match;
    logic             any_drains;
    logic             any_drop;
    logic [VOL_W-1:0] take;
  } chain_stat_t;

endpackage

[rtl/price_level_order_book_top.sv]
// Price-level order book with bid and ask sides, each a chain of LEVELS
// level cells kept in price order. An add or cancel word passes an eval
// state, in which every cell compares the price and the side's flags are
// collected, then an apply state, in which the cells merge, insert or shift
// in place. A new word is taken in the apply state, so words follow without
// an idle state between while results are taken. A clear walks each side
// one level per cycle, both sides at once, dropping generated levels and
// pausing on each drop. Results sit in an output register.
// uses plob_pkg and plob_chain
module price_level_order_book_top #(
  parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic                               side,
  input  logic [plob_pkg::PRICE_W-1:0]       price,
  input  logic [plob_pkg::VOL_W-1:0]         volume,
  input  logic                               generated,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [plob_pkg::VOL_W-1:0]         removed_volume,
  output logic [2:0]                         status,
  output logic [$clog2(LEVELS+1)-1:0]        bids_held,
  output logic [$clog2(LEVELS+1)-1:0]        asks_held,
  output logic [plob_pkg::PRICE_W-1:0]       best_bid_price,
  output logic [plob_pkg::PRICE_W-1:0]       best_ask_price
);

  localparam int CW = $clog2(LEVELS + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EVAL  = 4'b0010,
    ST_CLEAR = 4'b0100,
    ST_APPLY = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [1:0]                   rq_type;
  logic                         rq_side;
  logic [plob_pkg::PRICE_W-1:0] rq_price;
  logic [plob_pkg::VOL_W-1:0]   rq_vol;
  logic                         rq_gen;

  logic                         got_match;
  logic                         got_drains;
  logic [plob_pkg::VOL_W-1:0]   removed;

  logic [CW-1:0] bid_cnt, bid_cnt_next, ask_cnt, ask_cnt_next;
  logic [CW-1:0] bid_p, bid_p_next, ask_p, ask_p_next;
  logic [CW-1:0] tgt_cnt;

  plob_pkg::cell_cmd_t   bid_cmd, ask_cmd;
  plob_pkg::chain_stat_t bid_stat, ask_stat, sel_stat;
  logic [plob_pkg::PRICE_W-1:0] bid_head_next, ask_head_next;

  plob_pkg::op_t tgt_op;
  logic [2:0]    res_status;
  logic          accept, out_free, clear_done;

  plob_chain #(.LEVELS(LEVELS)) u_bid (
    .clk             (clk),
    .cmd             (bid_cmd),
    .bid_side        (1'b1),
    .cnt             (bid_cnt),
    .p               (bid_p),
    .stat            (bid_stat),
    .head_next_price (bid_head_next)
  );

  plob_chain #(.LEVELS(LEVELS)) u_ask (
    .clk             (clk),
    .cmd             (ask_cmd),
    .bid_side        (1'b0),
    .cnt             (ask_cnt),
    .p               (ask_p),
    .stat            (ask_stat),
    .head_next_price (ask_head_next)
  );

  assign in_stall   = !(state == ST_IDLE || state == ST_APPLY);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign clear_done = (bid_p >= bid_cnt) && (ask_p >= ask_cnt);
  assign sel_stat   = rq_side ? bid_stat : ask_stat;
  assign tgt_cnt    = rq_side ? bid_cnt : ask_cnt;

  always_comb begin
    tgt_op     = plob_pkg::OP_HOLD;
    res_status = plob_pkg::STAT_NOT_FOUND;
    unique case (rq_type)
      plob_pkg::REQ_ADD: begin
        if (got_match) begin
          tgt_op     = plob_pkg::OP_MERGE;
          res_status = plob_pkg::STAT_MERGED;
        end else if (tgt_cnt < CW'(LEVELS)) begin
          tgt_op     = plob_pkg::OP_INSERT;
          res_status = plob_pkg::STAT_NEW;
        end else begin
          res_status = plob_pkg::STAT_DROPPED;
        end
      end
      plob_pkg::REQ_CANCEL: begin
        if (got_match) begin
          tgt_op     = got_drains ? plob_pkg::OP_REMOVE : plob_pkg::OP_REDUCE;
          res_status = got_drains ? plob_pkg::STAT_REMOVED : plob_pkg::STAT_PARTIAL;
        end
      end
      plob_pkg::REQ_CLEAR: begin
        res_status = plob_pkg::STAT_CLEARED;
      end
      default: begin
        res_status = plob_pkg::STAT_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    bid_cmd.op     = plob_pkg::OP_HOLD;
    bid_cmd.price  = rq_price;
    bid_cmd.volume = rq_vol;
    bid_cmd.mark   = rq_gen;
    ask_cmd        = bid_cmd;
    bid_cnt_next   = bid_cnt;
    ask_cnt_next   = ask_cnt;
    bid_p_next     = bid_p;
    ask_p_next     = ask_p;
    if (state == ST_APPLY) begin
      if (rq_side) begin
        bid_cmd.op = tgt_op;
        if (tgt_op == plob_pkg::OP_INSERT) bid_cnt_next = bid_cnt + CW'(1);
        if (tgt_op == plob_pkg::OP_REMOVE) bid_cnt_next = bid_cnt - CW'(1);
      end else begin
        ask_cmd.op = tgt_op;
        if (tgt_op == plob_pkg::OP_INSERT) ask_cnt_next = ask_cnt + CW'(1);
        if (tgt_op == plob_pkg::OP_REMOVE) ask_cnt_next = ask_cnt - CW'(1);
      end
    end
    if (state == ST_CLEAR) begin
      if (bid_stat.any_drop) begin
        bid_cmd.op   = plob_pkg::OP_COMPACT;
        bid_cnt_next = bid_cnt - CW'(1);
      end else if (bid_p < bid_cnt) begin
        bid_p_next = bid_p + CW'(1);
      end
      if (ask_stat.any_drop) begin
        ask_cmd.op   = plob_pkg::OP_COMPACT;
        ask_cnt_next = ask_cnt - CW'(1);
      end else if (ask_p < ask_cnt) begin
        ask_p_next = ask_p + CW'(1);
      end
    end
    if (state == ST_EVAL) begin
      bid_p_next = '0;
      ask_p_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (rq_type == plob_pkg::REQ_CLEAR) state_next = ST_CLEAR;
        else if (out_free) state_next = ST_APPLY;
      end
      ST_CLEAR: begin
        if (clear_done && out_free) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = accept ? ST_EVAL : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bid_cnt   <= '0;
      ask_cnt   <= '0;
      bid_p     <= '0;
      ask_p     <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      bid_cnt <= bid_cnt_next;
      ask_cnt <= ask_cnt_next;
      bid_p   <= bid_p_next;
      ask_p   <= ask_p_next;
      if (state == ST_APPLY) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rq_type  <= req_type;
      rq_side  <= side;
      rq_price <= price;
      rq_vol   <= volume;
      rq_gen   <= generated;
    end
    if (state == ST_EVAL) begin
      got_match  <= sel_stat.any_match;
      got_drains <= sel_stat.any_drains;
      removed    <= sel_stat.take;
    end
    if (state == ST_APPLY) begin
      removed_volume <= (rq_type == plob_pkg::REQ_CANCEL) ? removed : '0;
      status         <= res_status;
      bids_held      <= bid_cnt_next;
      asks_held      <= ask_cnt_next;
      best_bid_price <= (bid_cnt_next != '0) ? bid_head_next : '0;
      best_ask_price <= (ask_cnt_next != '0) ? ask_head_next : '0;
    end
  end

endmodule

[rtl/plob_cell.sv]
// one price level of a book side: compares against the broadcast word and
// shifts toward its neighbors; uses plob_pkg
module plob_cell (
  input  logic                clk,
  input  plob_pkg::cell_cmd_t cmd,
  input  logic                bid_side,
  input  plob_pkg::pos_t      pos,
  input  plob_pkg::level_t    left_q,
  input  logic                left_better,
  input  plob_pkg::level_t    right_q,
  output plob_pkg::level_t    q,
  output plob_pkg::level_t    nxt,
  output plob_pkg::cell_flag_t flag
);

  logic [plob_pkg::VOL_W:0]   sum;
  logic [plob_pkg::VOL_W-1:0] part;

  always_comb begin
    flag.match  = pos.valid && (cmd.price == q.price);
    flag.better = !pos.valid ||
                  (bid_side ? (cmd.price > q.price) : (cmd.price < q.price));
    flag.drains = flag.match && (cmd.volume >= q.volume);
    flag.drop   = pos.at_p && pos.valid && q.mark;
    part        = (cmd.volume >= q.volume) ? q.volume : cmd.volume;
    flag.take   = flag.match ? part : '0;
    sum         = {1'b0, q.volume} + {1'b0, cmd.volume};
  end

  always_comb begin
    nxt = q;
    unique case (cmd.op)
      plob_pkg::OP_HOLD: begin
        nxt = q;
      end
      plob_pkg::OP_MERGE: begin
        if (flag.match) begin
          nxt.volume = sum[plob_pkg::VOL_W] ? plob_pkg::VOL_MAX
                                            : sum[plob_pkg::VOL_W-1:0];
        end
      end
      plob_pkg::OP_INSERT: begin
        if (flag.better) begin
          if (left_better) begin
            nxt = left_q;
          end else begin
            nxt.price  = cmd.price;
            nxt.volume = cmd.volume;
            nxt.mark   = cmd.mark;
          end
        end
      end
      plob_pkg::OP_REDUCE: begin
        if (flag.match) begin
          nxt.volume = q.volume - part;
        end
      end
      plob_pkg::OP_REMOVE: begin
        if (flag.match || flag.better) begin
          nxt = right_q;
        end
      end
      plob_pkg::OP_COMPACT: begin
        if (pos.past_p) begin
          nxt = right_q;
        end
      end
      default: begin
        nxt = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= nxt;
  end

endmodule

[rtl/plob_chain.sv]
// one book side: a row of plob_cell levels with position decode and flag
// collection; uses plob_pkg and plob_cell
module plob_chain #(
  parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
  input  logic                               clk,
  input  plob_pkg::cell_cmd_t                cmd,
  input  logic                               bid_side,
  input  logic [$clog2(LEVELS+1)-1:0]        cnt,
  input  logic [$clog2(LEVELS+1)-1:0]        p,
  output plob_pkg::chain_stat_t              stat,
  output logic [plob_pkg::PRICE_W-1:0]       head_next_price
);

  localparam int CW = $clog2(LEVELS + 1);

  plob_pkg::level_t     q    [LEVELS];
  plob_pkg::level_t     nxt  [LEVELS];
  plob_pkg::cell_flag_t flag [LEVELS];

  for (genvar j = 0; j < LEVELS; j++) begin : g_cell
    plob_pkg::pos_t   pos;
    plob_pkg::level_t left_q;
    plob_pkg::level_t right_q;
    logic             left_better;

    assign pos.valid  = CW'(j) < cnt;
    assign pos.at_p   = CW'(j) == p;
    assign pos.past_p = CW'(j) >= p;

    if (j == 0) begin : g_first
      assign left_q      = '0;
      assign left_better = 1'b0;
    end else begin : g_inner_l
      assign left_q      = q[j-1];
      assign left_better = flag[j-1].better;
    end

    if (j == LEVELS - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_inner_r
      assign right_q = q[j+1];
    end

    plob_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .bid_side    (bid_side),
      .pos         (pos),
      .left_q      (left_q),
      .left_better (left_better),
      .right_q     (right_q),
      .q           (q[j]),
      .nxt         (nxt[j]),
      .flag        (flag[j])
    );
  end

  always_comb begin
    stat = '0;
    for (int j = 0; j < LEVELS; j++) begin
      stat.any_match  = stat.any_match | flag[j].match;
      stat.any_drains = stat.any_drains | flag[j].drains;
      stat.any_drop   = stat.any_drop | flag[j].drop;
      stat.take       = stat.take | flag[j].take;
    end
  end

  assign head_next_price = nxt[0].price;

endmodule

[rtl/plob_checker.sv]
// port-level checks on result words of the order book, bound to the top
// uses plob_pkg; attaches to price_level_order_book_top
module plob_checker #(
  parameter int LEVELS = plob_pkg::LEVELS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [plob_pkg::VOL_W-1:0]   removed_volume,
  input logic [2:0]                   status,
  input logic [$clog2(LEVELS+1)-1:0]  bids_held,
  input logic [$clog2(LEVELS+1)-1:0]  asks_held,
  input logic [plob_pkg::PRICE_W-1:0] best_bid_price,
  input logic [plob_pkg::PRICE_W-1:0] best_ask_price
);

  localparam int CW = $clog2(LEVELS + 1);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bids_held <= CW'(LEVELS)) && (asks_held <= CW'(LEVELS)))
    else $error("level count above capacity");

  a_empty_price: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((bids_held != '0) || (best_bid_price == '0)) &&
                  ((asks_held != '0) || (best_ask_price == '0)))
    else $error("empty side shows a nonzero best price");

  a_dropped_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == plob_pkg::STAT_DROPPED) |->
      (bids_held == CW'(LEVELS)) || (asks_held == CW'(LEVELS)))
    else $error("dropped reported with room on both sides");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != plob_pkg::STAT_PARTIAL &&
     status != plob_pkg::STAT_REMOVED) |-> (removed_volume == '0))
    else $error("removed volume on a word that cancels nothing");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status) &&
      $stable(removed_volume) && $stable(bids_held) && $stable(asks_held))
    else $error("stalled result word changed");

endmodule

bind price_level_order_book_top plob_checker #(.LEVELS(LEVELS)) u_checker (.*);
